[rtl/dadj_pkg.sv]
// Shared types, field widths and codes for the deduplicating adjacency table.
`default_nettype none
package dadj_pkg;

  localparam int VERTEX_W   = 10;
  localparam int NB_W       = 10;
  localparam int OFS_W      = 14;
  localparam int RCNT_W     = 4;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 3;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 32;

  localparam int MAX_NEIGHBORS_DEF = 12;
  localparam int NUM_VERTICES_DEF  = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_EMIT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_DUPLICATE = 3'd1,
    STS_SELF_LOOP = 3'd2,
    STS_ROW_FULL  = 3'd3,
    STS_ROW_ENTRY = 3'd4,
    STS_ROW_EMPTY = 3'd5,
    STS_CLEARED   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOOK,
    S_EMIT,
    S_CLR_ACK
  } fsm_t;

endpackage
`default_nettype wire

[rtl/dadj_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dadj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  wire logic [WIDTH-1:0]                wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic      [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/dedup_adjacency_table_builder.sv]
// Adjacency table builder: a row of count plus neighbor slots per vertex in one wide RAM word.
// Add edge and empty-row emit read the row on accept, then compare and write back with the result.
// Emitting a row of n neighbors gives one beat per neighbor from the held row word.
// Clear and reset run a zeroing sweep over the row RAM, one row per cycle,
// during which no beat is accepted; the clear result follows the sweep.
// Reset is synchronous, active high; it also zeroes the running offset.
`default_nettype none
module dedup_adjacency_table_builder #(
  parameter int MAX_NEIGHBORS = dadj_pkg::MAX_NEIGHBORS_DEF,
  parameter int NUM_VERTICES  = dadj_pkg::NUM_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // vertex [9:0], neighbor [19:10], zero [23:20]
  input  wire logic [dadj_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // operation [1:0]
  input  wire logic [dadj_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // neighbor_out [9:0], csr_index [23:10], row_count [27:24], zero [31:28]
  output logic      [dadj_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status [2:0]
  output logic      [dadj_pkg::STATUS_W-1:0]   m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int AW    = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
  localparam int NBW   = dadj_pkg::NB_W;
  localparam int VW    = dadj_pkg::VERTEX_W;
  localparam int OW    = dadj_pkg::OFS_W;
  localparam int RW    = dadj_pkg::RCNT_W;
  localparam int WW    = MAX_NEIGHBORS * NBW + CW;
  localparam int MW    = VW + 18;

  dadj_pkg::fsm_t state, state_next;

  // item registers
  dadj_pkg::op_t   op_q;
  logic            self_q;
  logic [NBW-1:0]  nb_q;
  logic [AW-1:0]   idx_q;
  logic [CW-1:0]   emit_i;
  logic [OW-1:0]   offset;
  logic [AW-1:0]   sweep_addr;
  logic            clr_pend;

  // output register
  dadj_pkg::status_t out_status;
  logic [NBW-1:0]    out_nb;
  logic [OW-1:0]     out_csr;
  logic [RW-1:0]     out_cnt;
  logic              out_last;

  // combinational
  logic              accept;
  logic              out_free;
  logic [VW-1:0]     in_vertex;
  logic [NBW-1:0]    in_nb;
  dadj_pkg::op_t     in_op;
  logic [AW-1:0]     in_idx;
  logic [MW-1:0]     rem;

  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WW-1:0]     wr_data;
  logic [WW-1:0]     rd_data;

  logic [CW-1:0]     cnt;
  logic              dup;
  logic              full;
  logic [WW-1:0]     add_word;
  logic [NBW-1:0]    slot_sel;
  logic              last_entry;

  logic              out_load;
  dadj_pkg::status_t o_status;
  logic [NBW-1:0]    o_nb;
  logic [OW-1:0]     o_csr;
  logic [RW-1:0]     o_cnt;
  logic              o_last;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign in_vertex = s_axis_tdata[VW-1:0];
  assign in_nb     = s_axis_tdata[VW +: NBW];
  assign in_op     = dadj_pkg::op_t'(s_axis_tuser);

  // vertex modulo table size, restoring compare-subtract over the vertex bits
  always_comb begin
    rem = MW'(in_vertex);
    for (int k = VW - 1; k >= 0; k--) begin
      if (rem >= (MW'(NUM_VERTICES) << k)) begin
        rem = rem - (MW'(NUM_VERTICES) << k);
      end
    end
    in_idx = AW'(rem);
  end

  dadj_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_VERTICES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (in_idx),
    .rd_data (rd_data)
  );

  // row compare, append and entry select
  always_comb begin
    cnt      = rd_data[CW-1:0];
    dup      = 1'b0;
    add_word = rd_data;
    slot_sel = '0;
    for (int i = 0; i < MAX_NEIGHBORS; i++) begin
      if ((CW'(i) < cnt) && (rd_data[CW + i*NBW +: NBW] == nb_q)) begin
        dup = 1'b1;
      end
      if (CW'(i) == cnt) begin
        add_word[CW + i*NBW +: NBW] = nb_q;
      end
      if (CW'(i) == emit_i) begin
        slot_sel = rd_data[CW + i*NBW +: NBW];
      end
    end
    add_word[CW-1:0] = cnt + CW'(1);
    full       = (cnt >= CW'(MAX_NEIGHBORS));
    last_entry = (emit_i == cnt - CW'(1));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dadj_pkg::S_SWEEP: begin
        if (sweep_addr == AW'(NUM_VERTICES - 1)) begin
          state_next = clr_pend ? dadj_pkg::S_CLR_ACK : dadj_pkg::S_IDLE;
        end
      end
      dadj_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op) inside
            dadj_pkg::OP_ADD, dadj_pkg::OP_EMIT: state_next = dadj_pkg::S_LOOK;
            dadj_pkg::OP_CLEAR:                  state_next = dadj_pkg::S_SWEEP;
            default:                             state_next = dadj_pkg::S_IDLE;
          endcase
        end
      end
      dadj_pkg::S_LOOK: begin
        if (out_free) begin
          if (op_q == dadj_pkg::OP_EMIT && cnt != '0) begin
            state_next = dadj_pkg::S_EMIT;
          end else begin
            state_next = dadj_pkg::S_IDLE;
          end
        end
      end
      dadj_pkg::S_EMIT: begin
        if (out_free && last_entry) begin
          state_next = dadj_pkg::S_IDLE;
        end
      end
      dadj_pkg::S_CLR_ACK: begin
        if (out_free) begin
          state_next = dadj_pkg::S_IDLE;
        end
      end
      default: state_next = dadj_pkg::S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_axis_tready = (state == dadj_pkg::S_IDLE);
    rd_en         = accept;
    wr_en         = 1'b0;
    wr_addr       = idx_q;
    wr_data       = add_word;
    out_load      = 1'b0;
    o_status      = dadj_pkg::STS_CLEARED;
    o_nb          = '0;
    o_csr         = '0;
    o_cnt         = '0;
    o_last        = 1'b1;
    unique case (state)
      dadj_pkg::S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_addr;
        wr_data = '0;
      end
      dadj_pkg::S_IDLE: begin
      end
      dadj_pkg::S_LOOK: begin
        if (out_free) begin
          out_load = 1'b1;
          o_cnt    = RW'(cnt);
          if (op_q == dadj_pkg::OP_ADD) begin
            if (self_q) begin
              o_status = dadj_pkg::STS_SELF_LOOP;
            end else if (dup) begin
              o_status = dadj_pkg::STS_DUPLICATE;
            end else if (full) begin
              o_status = dadj_pkg::STS_ROW_FULL;
            end else begin
              o_status = dadj_pkg::STS_ADDED;
              o_cnt    = RW'(cnt + CW'(1));
              wr_en    = 1'b1;
            end
          end else if (cnt == '0) begin
            o_status = dadj_pkg::STS_ROW_EMPTY;
            o_csr    = offset;
          end else begin
            // row entries follow from the emit state
            out_load = 1'b0;
          end
        end
      end
      dadj_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_status = dadj_pkg::STS_ROW_ENTRY;
          o_nb     = slot_sel;
          o_csr    = offset + OW'(emit_i);
          o_cnt    = RW'(cnt);
          o_last   = last_entry;
        end
      end
      dadj_pkg::S_CLR_ACK: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dadj_pkg::S_SWEEP;
      sweep_addr <= '0;
      clr_pend   <= 1'b0;
      offset     <= '0;
      emit_i     <= '0;
    end else begin
      state <= state_next;
      if (state == dadj_pkg::S_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (accept) begin
        emit_i <= '0;
        if (in_op == dadj_pkg::OP_CLEAR) begin
          offset     <= '0;
          sweep_addr <= '0;
          clr_pend   <= 1'b1;
        end
      end
      if (state == dadj_pkg::S_CLR_ACK && out_free) begin
        clr_pend <= 1'b0;
      end
      if (state == dadj_pkg::S_EMIT && out_free) begin
        emit_i <= emit_i + CW'(1);
        if (last_entry) begin
          offset <= offset + OW'(cnt);
        end
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= in_op;
      self_q <= (in_vertex == in_nb);
      nb_q   <= in_nb;
      idx_q  <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= o_status;
      out_nb     <= o_nb;
      out_csr    <= o_csr;
      out_cnt    <= o_cnt;
      out_last   <= o_last;
    end
  end

  assign m_axis_tdata = {(dadj_pkg::M_TDATA_W - NBW - OW - RW)'(0), out_cnt, out_csr, out_nb};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

endmodule
`default_nettype wire
